FILE: hdl/cls_pkg.sv
`timescale 1ns / 1ps
package cls_pkg;

  localparam int MAX_PARTICLES     = 1024;
  localparam int NUM_BINS          = 512;
  localparam int MAX_PER_BIN       = 16;
  localparam int MAX_NEIGHBOR_BINS = 16;
  localparam int MAX_MATCHES       = 64;

  localparam int POS_W  = 21;
  localparam int SQ_W   = 2 * POS_W;
  localparam int ACC_W  = SQ_W + 2;
  localparam int PIDX_W = $clog2(MAX_PARTICLES);
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int SLOT_W = $clog2(MAX_PER_BIN);
  localparam int NB_W   = $clog2(MAX_NEIGHBOR_BINS);
  localparam int HIT_W  = $clog2(MAX_MATCHES);
  localparam int CNT_W  = 7;
  localparam int CFG_W  = 42;

  typedef logic [2:0] op_t;
  localparam op_t OP_WR_PART  = 3'd0;
  localparam op_t OP_WR_SLOT  = 3'd1;
  localparam op_t OP_SET_CNT  = 3'd2;
  localparam op_t OP_WR_FWD   = 3'd3;
  localparam op_t OP_WR_REV   = 3'd4;
  localparam op_t OP_QUERY    = 3'd5;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOX_X   = 3'd0;
  localparam cfg_idx_t CFG_BOX_Y   = 3'd1;
  localparam cfg_idx_t CFG_BOX_Z   = 3'd2;
  localparam cfg_idx_t CFG_CUTOFF  = 3'd3;
  localparam cfg_idx_t CFG_NB_USED = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] len;
  } axis_in_t;

endpackage

FILE: hdl/cell_list_pair_search.sv
`timescale 1ns / 1ps
// Cell-list pair search. Write beats (ops 0 to 4) are taken whenever the
// block is idle. A query first fetches the queried particle, then walks the
// home cell, neighbor_bins_used (capped at 16) forward cells and as many
// reverse cells, testing one candidate at a time through a single shared
// fold-and-square unit; each free candidate of the wanted kind goes through
// the three axes in the two-stage unit, then the compare. Partners are then
// emitted one at a time, each held until the output is not stalled; an empty
// result gives a single beat. Input is stalled throughout a query. After
// reset the block runs a pass zeroing all 512 cell counts and takes no input
// beat meanwhile.
module cell_list_pair_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  cls_pkg::cfg_idx_t            cfg_index,
  input  logic [cls_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cls_pkg::op_t                 in_op,
  input  logic [9:0]                   in_particle_index,
  input  logic [8:0]                   in_bin_index,
  input  logic [3:0]                   in_slot_index,
  input  logic [9:0]                   in_entry_value,
  input  logic [20:0]                  in_pos_x,
  input  logic [20:0]                  in_pos_y,
  input  logic [20:0]                  in_pos_z,
  input  logic [7:0]                   in_kind,
  input  logic                         in_has_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [9:0]                   out_partner_index,
  output logic                         out_match_valid,
  output logic [6:0]                   out_match_count,
  output logic                         out_overflow,
  output logic                         out_last
);
  import cls_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SELF_RD, S_SELF_W, S_CELL, S_TBL_W, S_CNT_RD, S_CNT_W,
    S_SLOT, S_SLOT_W, S_PART_W, S_AX, S_CMP, S_NEXT, S_EMIT, S_EMIT_W, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_HOME, PH_FWD, PH_REV} phase_t;

  state_t state_r;
  phase_t phase_r;

  logic [POS_W-1:0] box_x_r, box_y_r, box_z_r;
  logic [CFG_W-1:0] cutoff_r;
  logic [4:0]       nb_used_r;

  // stores
  logic [3*POS_W-1:0] pos_mem  [MAX_PARTICLES];
  logic [17:0]        attr_mem [MAX_PARTICLES];
  logic [PIDX_W-1:0]  slot_mem [NUM_BINS*MAX_PER_BIN];
  logic [4:0]         cnt_mem  [NUM_BINS];
  logic [BIN_W-1:0]   fwd_mem  [NUM_BINS*MAX_NEIGHBOR_BINS];
  logic [BIN_W-1:0]   rev_mem  [NUM_BINS*MAX_NEIGHBOR_BINS];
  logic [PIDX_W-1:0]  hit_mem  [MAX_MATCHES];

  logic [3*POS_W-1:0] pos_q_r;
  logic [17:0]        attr_q_r;
  logic [PIDX_W-1:0]  slot_q_r;
  logic [4:0]         cnt_q_r;
  logic [BIN_W-1:0]   fwd_q_r, rev_q_r;
  logic [PIDX_W-1:0]  hit_q_r;

  logic [PIDX_W-1:0] q_idx_r;
  logic [3*POS_W-1:0] self_pos_r;
  logic [7:0]        self_kind_r;
  logic [BIN_W-1:0]  home_r, cell_r, clr_r;
  logic [4:0]        nb_r, n_r, k_r;
  logic [2:0]        ax_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CNT_W-1:0]  hit_cnt_r, e_idx_r;
  logic              over_r;
  logic              out_valid_r, out_match_valid_r, out_overflow_r, out_last_r;
  logic [9:0]        out_partner_r;
  logic [6:0]        out_count_r;

  logic              in_acc;
  logic [4:0]        used;
  logic [PIDX_W-1:0] pa_addr;
  logic [SQ_W-1:0]   sq;
  axis_in_t          axis_in;
  logic              kind_ok;
  logic [CNT_W-1:0]  e_next;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign used     = (nb_used_r > 5'(MAX_NEIGHBOR_BINS)) ? 5'(MAX_NEIGHBOR_BINS) : nb_used_r;
  assign pa_addr  = (state_r == S_SELF_RD) ? q_idx_r : slot_q_r;
  assign kind_ok  = (attr_q_r[17:10] == self_kind_r) == (phase_r == PH_REV);
  assign e_next   = e_idx_r + 1'b1;

  always_comb begin
    case (ax_r)
      3'd0: axis_in = '{a: self_pos_r[62:42], b: pos_q_r[62:42], len: box_x_r};
      3'd1: axis_in = '{a: self_pos_r[41:21], b: pos_q_r[41:21], len: box_y_r};
      default: axis_in = '{a: self_pos_r[20:0], b: pos_q_r[20:0], len: box_z_r};
    endcase
  end

  cls_axis_sq u_axis (.clk(clk), .axis_in(axis_in), .sq_r(sq));

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_WR_PART) begin
      pos_mem[in_particle_index]  <= {in_pos_x, in_pos_y, in_pos_z};
      attr_mem[in_particle_index] <= {in_kind, in_has_free, in_bin_index};
    end
    pos_q_r  <= pos_mem[pa_addr];
    attr_q_r <= attr_mem[pa_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_WR_SLOT) begin
      slot_mem[{in_bin_index, in_slot_index}] <= in_entry_value;
    end
    slot_q_r <= slot_mem[{cell_r, k_r[SLOT_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      cnt_mem[clr_r] <= '0;
    end else if (in_acc && in_op == OP_SET_CNT) begin
      cnt_mem[in_bin_index] <= (in_entry_value > 10'(MAX_PER_BIN)) ?
                               5'(MAX_PER_BIN) : in_entry_value[4:0];
    end
    cnt_q_r <= cnt_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_WR_FWD && !in_entry_value[9]) begin
      fwd_mem[{in_bin_index, in_slot_index}] <= in_entry_value[BIN_W-1:0];
    end
    if (in_acc && in_op == OP_WR_REV && !in_entry_value[9]) begin
      rev_mem[{in_bin_index, in_slot_index}] <= in_entry_value[BIN_W-1:0];
    end
    fwd_q_r <= fwd_mem[{home_r, nb_r[NB_W-1:0]}];
    rev_q_r <= rev_mem[{home_r, nb_r[NB_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP && acc_r < {2'b00, cutoff_r} && hit_cnt_r < CNT_W'(MAX_MATCHES)) begin
      hit_mem[hit_cnt_r[HIT_W-1:0]] <= slot_q_r;
    end
    hit_q_r <= hit_mem[e_idx_r[HIT_W-1:0]];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r   <= '1;
      box_y_r   <= '1;
      box_z_r   <= '1;
      cutoff_r  <= '0;
      nb_used_r <= 5'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X:   box_x_r   <= cfg_data[POS_W-1:0];
        CFG_BOX_Y:   box_y_r   <= cfg_data[POS_W-1:0];
        CFG_BOX_Z:   box_z_r   <= cfg_data[POS_W-1:0];
        CFG_CUTOFF:  cutoff_r  <= cfg_data;
        CFG_NB_USED: nb_used_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HOME;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BIN_W'(NUM_BINS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc && in_op == OP_QUERY) begin
            q_idx_r <= in_particle_index;
            state_r <= S_SELF_RD;
          end
        end
        S_SELF_RD: state_r <= S_SELF_W;
        S_SELF_W: begin
          self_pos_r  <= pos_q_r;
          self_kind_r <= attr_q_r[17:10];
          home_r      <= attr_q_r[BIN_W-1:0];
          phase_r     <= PH_HOME;
          nb_r        <= '0;
          hit_cnt_r   <= '0;
          over_r      <= 1'b0;
          state_r     <= S_CELL;
        end
        S_CELL: begin
          if (phase_r == PH_HOME) begin
            cell_r  <= home_r;
            state_r <= S_CNT_RD;
          end else begin
            state_r <= S_TBL_W;
          end
        end
        S_TBL_W: begin
          cell_r  <= (phase_r == PH_FWD) ? fwd_q_r : rev_q_r;
          state_r <= S_CNT_RD;
        end
        S_CNT_RD: state_r <= S_CNT_W;
        S_CNT_W: begin
          n_r     <= cnt_q_r;
          k_r     <= '0;
          state_r <= S_SLOT;
        end
        S_SLOT: state_r <= (k_r >= n_r) ? S_NEXT : S_SLOT_W;
        S_SLOT_W: state_r <= S_PART_W;
        S_PART_W: begin
          if (attr_q_r[9] && kind_ok) begin
            ax_r    <= '0;
            acc_r   <= '0;
            state_r <= S_AX;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SLOT;
          end
        end
        S_AX: begin
          // products arrive from the axis unit after its e_r and sq_r registers
          ax_r <= ax_r + 1'b1;
          if (ax_r >= 3'd2) acc_r <= acc_r + ACC_W'(sq);
          if (ax_r == 3'd4) state_r <= S_CMP;
        end
        S_CMP: begin
          if (acc_r < {2'b00, cutoff_r}) begin
            if (hit_cnt_r < CNT_W'(MAX_MATCHES)) hit_cnt_r <= hit_cnt_r + 1'b1;
            else over_r <= 1'b1;
          end
          k_r     <= k_r + 1'b1;
          state_r <= S_SLOT;
        end
        S_NEXT: begin
          case (phase_r)
            PH_HOME: begin
              if (used == '0) begin
                state_r <= S_EMIT;
              end else begin
                phase_r <= PH_FWD;
                nb_r    <= '0;
                state_r <= S_CELL;
              end
            end
            PH_FWD: begin
              if (nb_r + 1'b1 == used) begin
                phase_r <= PH_REV;
                nb_r    <= '0;
              end else begin
                nb_r <= nb_r + 1'b1;
              end
              state_r <= S_CELL;
            end
            default: begin
              if (nb_r + 1'b1 == used) begin
                state_r <= S_EMIT;
              end else begin
                nb_r    <= nb_r + 1'b1;
                state_r <= S_CELL;
              end
            end
          endcase
          e_idx_r <= '0;
        end
        S_EMIT: begin
          if (hit_cnt_r == '0) begin
            out_partner_r     <= '0;
            out_match_valid_r <= 1'b0;
            out_count_r       <= '0;
            out_overflow_r    <= 1'b0;
            out_last_r        <= 1'b1;
            out_valid_r       <= 1'b1;
            state_r           <= S_OUT;
          end else begin
            state_r <= S_EMIT_W;
          end
        end
        S_EMIT_W: begin
          out_partner_r     <= hit_q_r;
          out_match_valid_r <= 1'b1;
          out_count_r       <= e_next;
          out_last_r        <= (e_next == hit_cnt_r);
          out_overflow_r    <= (e_next == hit_cnt_r) && over_r;
          out_valid_r       <= 1'b1;
          state_r           <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              e_idx_r <= e_next;
              state_r <= S_EMIT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_partner_index = out_partner_r;
  assign out_match_valid   = out_match_valid_r;
  assign out_match_count   = out_count_r;
  assign out_overflow      = out_overflow_r;
  assign out_last          = out_last_r;

endmodule

FILE: hdl/cls_axis_sq.sv
`timescale 1ns / 1ps
// Shared per-axis unit: minimum-image fold, then square. Two register stages.
module cls_axis_sq (
  input  logic                    clk,
  input  cls_pkg::axis_in_t       axis_in,
  output logic [cls_pkg::SQ_W-1:0] sq_r
);
  import cls_pkg::*;

  logic [POS_W-1:0] diff;
  logic [POS_W-1:0] fold;
  logic [POS_W-1:0] e_r;

  always_comb begin
    diff = (axis_in.a >= axis_in.b) ? axis_in.a - axis_in.b : axis_in.b - axis_in.a;
    fold = diff;
    if ({diff, 1'b0} > {1'b0, axis_in.len}) begin
      fold = (axis_in.len >= diff) ? axis_in.len - diff : diff - axis_in.len;
    end
  end

  always_ff @(posedge clk) begin
    e_r  <= fold;
    sq_r <= e_r * e_r;
  end

endmodule

FILE: tb/sv/cell_list_pair_search_tb.sv
`timescale 1ns / 1ps
module cell_list_pair_search_tb;
  import cls_pkg::*;

  localparam op_t OP_RSVD_6 = 3'd6;
  localparam op_t OP_RSVD_7 = 3'd7;
  localparam int  N_WORK    = 4;
  localparam int  N_HOME    = 2;
  localparam int  N_PHASES  = 6;

  typedef struct {
    op_t         op;
    logic [9:0]  pidx;
    logic [8:0]  bin;
    logic [3:0]  slot;
    logic [9:0]  val;
    logic [20:0] px, py, pz;
    logic [7:0]  kind;
    logic        free;
  } beat_t;

  typedef struct {
    logic [9:0] partner;
    logic       mvalid;
    logic [6:0] count;
    logic       ovf;
    logic       last;
  } hit_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  cfg_idx_t cfg_index = CFG_BOX_X;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  op_t in_op = OP_WR_PART;
  logic [9:0] in_particle_index = '0;
  logic [8:0] in_bin_index = '0;
  logic [3:0] in_slot_index = '0;
  logic [9:0] in_entry_value = '0;
  logic [20:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [7:0] in_kind = '0;
  logic in_has_free = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [9:0] out_partner_index;
  logic out_match_valid;
  logic [6:0] out_match_count;
  logic out_overflow;
  logic out_last;

  cell_list_pair_search uut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [20:0] box_x = '1, box_y = '1, box_z = '1;
  logic [41:0] cutoff = '0;
  logic [4:0]  nb_used = 5'd13;
  logic [20:0] p_pos [MAX_PARTICLES][3];
  logic [7:0]  p_kind [MAX_PARTICLES];
  logic        p_free [MAX_PARTICLES];
  logic [8:0]  p_home [MAX_PARTICLES];
  logic [9:0]  cell_member [NUM_BINS*MAX_PER_BIN];
  logic [4:0]  cell_fill [NUM_BINS];
  logic [8:0]  fwd_cell [NUM_BINS*MAX_NEIGHBOR_BINS];
  logic [8:0]  rev_cell [NUM_BINS*MAX_NEIGHBOR_BINS];
  int          partners [$];
  bit          partners_over;

  hit_t  pending_hits [$];
  beat_t beat_q [$];
  int    mismatches = 0;

  // stimulus-side bookkeeping; particles live in the first N_HOME cells
  bit   placed [MAX_PARTICLES];
  int   placed_list [$];
  int   work_cell [N_WORK] = '{0, 5, 341, 511};

  function automatic longint unsigned axis_sq(logic [20:0] a, logic [20:0] b,
                                              logic [20:0] len);
    longint unsigned e;
    e = (a >= b) ? 64'(a - b) : 64'(b - a);
    if (2 * e > 64'(len)) e = (64'(len) >= e) ? 64'(len) - e : e - 64'(len);
    return e * e;
  endfunction

  function automatic void walk_cell(int self, int c, bit same);
    int p;
    longint unsigned r2;
    for (int k = 0; k < int'(cell_fill[c]); k++) begin
      p = int'(cell_member[c*MAX_PER_BIN + k]);
      if (!p_free[p] || ((p_kind[p] == p_kind[self]) != same)) continue;
      r2 = axis_sq(p_pos[self][0], p_pos[p][0], box_x)
         + axis_sq(p_pos[self][1], p_pos[p][1], box_y)
         + axis_sq(p_pos[self][2], p_pos[p][2], box_z);
      if (r2 < 64'(cutoff)) begin
        if (partners.size() < MAX_MATCHES) partners.push_back(p);
        else partners_over = 1;
      end
    end
  endfunction

  function automatic void apply_beat(beat_t b);
    int home, used;
    hit_t h;
    case (b.op)
      OP_WR_PART: begin
        p_pos[b.pidx][0] = b.px;
        p_pos[b.pidx][1] = b.py;
        p_pos[b.pidx][2] = b.pz;
        p_kind[b.pidx] = b.kind;
        p_free[b.pidx] = b.free;
        p_home[b.pidx] = b.bin;
      end
      OP_WR_SLOT: cell_member[b.bin*MAX_PER_BIN + b.slot] = b.val;
      OP_SET_CNT: cell_fill[b.bin] = (b.val > 10'(MAX_PER_BIN)) ? 5'(MAX_PER_BIN)
                                                                : b.val[4:0];
      OP_WR_FWD: if (b.val < NUM_BINS) fwd_cell[b.bin*MAX_NEIGHBOR_BINS + b.slot] = b.val[8:0];
      OP_WR_REV: if (b.val < NUM_BINS) rev_cell[b.bin*MAX_NEIGHBOR_BINS + b.slot] = b.val[8:0];
      OP_QUERY: begin
        partners.delete();
        partners_over = 0;
        home = int'(p_home[b.pidx]);
        used = (nb_used > 5'(MAX_NEIGHBOR_BINS)) ? MAX_NEIGHBOR_BINS : int'(nb_used);
        walk_cell(int'(b.pidx), home, 0);
        for (int i = 0; i < used; i++)
          walk_cell(int'(b.pidx), int'(fwd_cell[home*MAX_NEIGHBOR_BINS + i]), 0);
        for (int i = 0; i < used; i++)
          walk_cell(int'(b.pidx), int'(rev_cell[home*MAX_NEIGHBOR_BINS + i]), 1);
        if (partners.size() == 0) begin
          h = '{partner: '0, mvalid: 1'b0, count: '0, ovf: 1'b0, last: 1'b1};
          pending_hits.push_back(h);
        end
        foreach (partners[k]) begin
          h.partner = 10'(partners[k]);
          h.mvalid  = 1;
          h.count   = 7'(k + 1);
          h.last    = (k == partners.size() - 1);
          h.ovf     = h.last && partners_over;
          pending_hits.push_back(h);
        end
      end
      default: ;
    endcase
  endfunction

  // ---- stimulus construction ----
  function automatic beat_t blank(op_t op);
    beat_t b;
    b = '{op: op, pidx: '0, bin: '0, slot: '0, val: '0, px: '0, py: '0, pz: '0,
          kind: '0, free: 1'b0};
    return b;
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_particle(int idx, logic [20:0] x, logic [20:0] y,
                                       logic [20:0] z);
    beat_t b;
    b = blank(OP_WR_PART);
    b.pidx = 10'(idx);
    b.bin  = 9'(work_cell[$urandom_range(0, N_HOME-1)]);
    b.px = x; b.py = y; b.pz = z;
    b.kind = pick_kind();
    b.free = ($urandom_range(0, 3) != 0);
    if (!placed[idx]) placed_list.push_back(idx);
    placed[idx] = 1;
    beat_q.push_back(b);
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int sel, wsel;
    sel = $urandom_range(0, 99);
    wsel = work_cell[$urandom_range(0, N_WORK-1)];
    if (sel < 32) begin
      b = blank(OP_QUERY);
      b.pidx = 10'(placed_list[$urandom_range(0, placed_list.size()-1)]);
    end else if (sel < 45) begin
      b = blank(OP_WR_PART);
      b.pidx = 10'($urandom_range(0, MAX_PARTICLES-1));
      b.bin = 9'(work_cell[$urandom_range(0, N_HOME-1)]);
      b.px = 21'($urandom); b.py = 21'($urandom); b.pz = 21'($urandom);
      b.kind = pick_kind();
      b.free = ($urandom_range(0, 3) != 0);
      if (!placed[b.pidx]) placed_list.push_back(int'(b.pidx));
      placed[b.pidx] = 1;
    end else if (sel < 60) begin
      b = blank(OP_WR_SLOT);
      b.bin = $urandom_range(0, 1) ? 9'(wsel) : 9'($urandom_range(0, NUM_BINS-1));
      b.slot = 4'($urandom);
      b.val = 10'(placed_list[$urandom_range(0, placed_list.size()-1)]);
    end else if (sel < 75) begin
      b = blank(OP_SET_CNT);
      b.bin = $urandom_range(0, 1) ? 9'(wsel) : 9'($urandom_range(0, NUM_BINS-1));
      b.val = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 18));
    end else if (sel < 95) begin
      b = blank((sel < 85) ? OP_WR_FWD : OP_WR_REV);
      b.slot = 4'($urandom);
      b.bin = ($urandom_range(0, 2) != 0) ? 9'(wsel) : 9'($urandom_range(0, NUM_BINS-1));
      // beyond the table a cell number is dropped
      b.val = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(NUM_BINS, 1023))
                                           : 10'(work_cell[$urandom_range(0, N_WORK-1)]);
    end else begin
      b = blank($urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7);
      b.pidx = 10'($urandom); b.bin = 9'($urandom);
      b.slot = 4'($urandom); b.val = 10'($urandom);
    end
    // stray bits on fields the op does not use
    if (b.op != OP_WR_PART && $urandom_range(0, 3) == 0) begin
      b.px = 21'($urandom); b.py = 21'($urandom); b.pz = 21'($urandom);
      b.kind = 8'($urandom); b.free = 1'($urandom);
    end
    return b;
  endfunction

  // ---- driver ----
  int    burst_left = 4;
  int    gap_left = 0;
  beat_t cur;

  always @(posedge clk) begin
    bit nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 0;
    end else begin
      if (in_valid && !in_stall) apply_beat(cur);
      if (!in_valid || !in_stall) begin
        nv = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_q.size() > 0) begin
          cur = beat_q.pop_front();
          in_op <= cur.op;
          in_particle_index <= cur.pidx;
          in_bin_index <= cur.bin;
          in_slot_index <= cur.slot;
          in_entry_value <= cur.val;
          in_pos_x <= cur.px;
          in_pos_y <= cur.py;
          in_pos_z <= cur.pz;
          in_kind <= cur.kind;
          in_has_free <= cur.free;
          nv = 1;
          if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
    in_valid <= nv;
  end

  // ---- result monitor and stall pattern ----
  int stall_mode = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: partner %0d count %0d last %0b",
                   out_partner_index, out_match_count, out_last);
      end else begin
        e = pending_hits.pop_front();
        if (out_partner_index !== e.partner || out_match_valid !== e.mvalid ||
            out_match_count !== e.count || out_overflow !== e.ovf ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp p=%0d v=%0b n=%0d o=%0b l=%0b, got p=%0d v=%0b n=%0d o=%0b l=%0b",
                     e.partner, e.mvalid, e.count, e.ovf, e.last,
                     out_partner_index, out_match_valid, out_match_count,
                     out_overflow, out_last);
        end
      end
    end
    if (++stall_tick >= 40) begin
      stall_tick = 0;
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---- sequencing ----
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (beat_q.size() != 0 || in_valid || pending_hits.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_BOX_X:  box_x = data[20:0];
      CFG_BOX_Y:  box_y = data[20:0];
      CFG_BOX_Z:  box_z = data[20:0];
      CFG_CUTOFF: cutoff = data[41:0];
      default:    nb_used = data[4:0];
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_phase(int ph);
    logic [20:0] bx, by, bz;
    logic [41:0] cut;
    logic [4:0]  nb;
    case (ph)
      1: begin bx = '1; by = '1; bz = '1; cut = '1; nb = 5'd16; end
      2: begin bx = 21'd1; by = 21'd1; bz = 21'd1; cut = 42'h200_0000_0000; nb = 5'd0; end
      3: begin bx = '0; by = '0; bz = '0; cut = 42'({$urandom, $urandom}); nb = 5'd31; end
      default: begin
        bx = 21'($urandom); by = 21'($urandom); bz = 21'($urandom);
        cut = {10'($urandom_range(0, 1023)), 32'($urandom)};
        nb = 5'($urandom);
      end
    endcase
    write_reg(CFG_BOX_X, CFG_W'(bx));
    write_reg(CFG_BOX_Y, CFG_W'(by));
    write_reg(CFG_BOX_Z, CFG_W'(bz));
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_NB_USED, CFG_W'(nb));
  endtask

  initial begin
    beat_t b;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // world set-up: particles, every slot of every working cell, full tables
    // for the home cells
    add_particle(0, '0, '0, '0);
    add_particle(1023, '1, '1, '1);
    add_particle(512, 21'h100000, 21'h0FFFFF, 21'h155555);
    for (int i = 1; i < 14; i++)
      add_particle(i, 21'($urandom), 21'($urandom), 21'($urandom));
    foreach (work_cell[w]) begin
      for (int s = 0; s < MAX_PER_BIN; s++) begin
        b = blank(OP_WR_SLOT);
        b.bin = 9'(work_cell[w]); b.slot = 4'(s);
        b.val = 10'(placed_list[$urandom_range(0, placed_list.size()-1)]);
        beat_q.push_back(b);
        if (w < N_HOME) begin
          b = blank(OP_WR_FWD);
          b.bin = 9'(work_cell[w]); b.slot = 4'(s);
          b.val = 10'(work_cell[$urandom_range(0, N_WORK-1)]);
          beat_q.push_back(b);
          b.op = OP_WR_REV; b.val = 10'(work_cell[$urandom_range(0, N_WORK-1)]);
          beat_q.push_back(b);
        end
      end
      b = blank(OP_SET_CNT);
      b.bin = 9'(work_cell[w]); b.val = 10'(MAX_PER_BIN);
      beat_q.push_back(b);
    end

    // directed: oversize counts, dropped cell numbers, reserved ops, queries
    b = blank(OP_SET_CNT); b.bin = 9'd5; b.val = 10'h3FF; beat_q.push_back(b);
    b.bin = 9'd341; b.val = 10'd17; beat_q.push_back(b);
    b.bin = 9'd511; b.val = 10'd0; beat_q.push_back(b);
    b = blank(OP_WR_FWD); b.bin = 9'd0; b.slot = 4'd15; b.val = 10'd600; beat_q.push_back(b);
    b.op = OP_WR_REV; b.val = 10'h3FF; beat_q.push_back(b);
    b = blank(OP_RSVD_6); b.pidx = '1; b.bin = '1; b.slot = '1; b.val = '1;
    b.px = '1; b.py = '1; b.pz = '1; b.kind = '1; b.free = 1;
    beat_q.push_back(b);
    b.op = OP_RSVD_7; beat_q.push_back(b);
    b = blank(OP_QUERY); b.pidx = 10'd0; beat_q.push_back(b);
    b.pidx = 10'd1023; beat_q.push_back(b);
    b.pidx = 10'd512; beat_q.push_back(b);
    wait_drained();

    for (int ph = 1; ph < N_PHASES; ph++) begin
      set_phase(ph);
      for (int q = 0; q < 3; q++) begin
        b = blank(OP_QUERY); b.pidx = 10'(placed_list[q]); beat_q.push_back(b);
      end
      repeat (8) beat_q.push_back(rand_beat());
      wait_drained();
    end

    if (mismatches == 0 && pending_hits.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
